>>> rtl/sspfc_pkg.sv
// Package for the span sprite pixel format converter.
// Holds the register indexes, the pixel masks, the shared structs and the conversion function.
// No dependencies.
package sspfc_pkg;

  localparam int unsigned WordWidth = 16;
  localparam int unsigned CfgIdxWidth = 8;
  localparam int unsigned CfgDataWidth = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] CfgIdxLineCount = 8'd0;
  localparam logic [CfgIdxWidth-1:0] CfgIdxTo555Mode = 8'd1;

  // Pixel field masks.
  localparam logic [WordWidth-1:0] MaskHigh565 = 16'hffc0;
  localparam logic [WordWidth-1:0] MaskBlue    = 16'h001f;
  localparam logic [WordWidth-1:0] MaskHigh555 = 16'h7fe0;

  typedef struct packed {
    logic [WordWidth-1:0] line_count;
    logic                 to_555_mode;
  } cfg_t;

  typedef struct packed {
    logic [WordWidth-1:0] word_out;
    logic                 was_pixel;
    logic                 sprite_end;
  } result_t;

  function automatic logic [WordWidth-1:0] convert_pixel(input logic [WordWidth-1:0] w,
                                                         input logic to_555);
    logic [WordWidth-1:0] res;
    if (to_555) begin
      res = ((w & MaskHigh565) >> 1) | (w & MaskBlue);
    end else begin
      res = ((w & MaskHigh555) << 1) | (w & MaskBlue);
    end
    return res;
  endfunction

endpackage

>>> rtl/sspfc_if.sv
// Handshake channel interfaces of the span sprite pixel format converter.
// Input word channel, result channel and configuration write channel.
// Depends on sspfc_pkg for the widths.
interface sspfc_word_if;
  logic                                valid;
  logic                                ready;
  logic [sspfc_pkg::WordWidth-1:0]     word_in;

  modport source (output valid, output word_in, input ready);
  modport sink (input valid, input word_in, output ready);
endinterface

interface sspfc_result_if;
  logic                                valid;
  logic                                ready;
  logic [sspfc_pkg::WordWidth-1:0]     word_out;
  logic                                was_pixel;
  logic                                sprite_end;

  modport source (output valid, output word_out, output was_pixel, output sprite_end,
                  input ready);
  modport sink (input valid, input word_out, input was_pixel, input sprite_end,
                output ready);
endinterface

interface sspfc_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [sspfc_pkg::CfgIdxWidth-1:0]     index;
  logic [sspfc_pkg::CfgDataWidth-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/sspfc_cfg_regs.sv
// Configuration registers of the span sprite pixel format converter.
// Decodes register writes into line count and conversion mode.
// Depends on sspfc_pkg.
module sspfc_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 wr_en_i,
  input  logic [sspfc_pkg::CfgIdxWidth-1:0]    wr_index_i,
  input  logic [sspfc_pkg::CfgDataWidth-1:0]   wr_data_i,
  output sspfc_pkg::cfg_t                      cfg_o
);

  sspfc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        sspfc_pkg::CfgIdxLineCount: cfg_d.line_count = wr_data_i;
        sspfc_pkg::CfgIdxTo555Mode: cfg_d.to_555_mode = wr_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_count  <= '0;
      cfg_q.to_555_mode <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/sspfc_parser.sv
// Span stream parser of the span sprite pixel format converter.
// Tracks span, pixel and line counts, converts pixel words and flags the sprite end.
// Depends on sspfc_pkg.
module sspfc_parser (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic [sspfc_pkg::WordWidth-1:0]  word_i,
  input  sspfc_pkg::cfg_t                  cfg_i,
  output sspfc_pkg::result_t               result_o
);

  localparam int unsigned W = sspfc_pkg::WordWidth;

  typedef enum logic [1:0] {
    PhSpans = 2'd0,
    PhSkip  = 2'd1,
    PhCount = 2'd2,
    PhPixel = 2'd3
  } phase_e;

  phase_e         phase_q, phase_d;
  logic [W-1:0]   lines_done_q, lines_done_d;
  logic [W-1:0]   spans_left_q, spans_left_d;
  logic [W-1:0]   pixels_left_q, pixels_left_d;

  logic [W-1:0]   span_dec, pix_dec;
  logic           line_last;
  logic           do_span, do_line;

  assign span_dec  = spans_left_q - W'(1);
  assign pix_dec   = pixels_left_q - W'(1);
  // The sprite ends when this line brings the count up to the configured line count.
  assign line_last = ({1'b0, lines_done_q} + (W+1)'(1)) >= {1'b0, cfg_i.line_count};

  always_comb begin
    phase_d       = phase_q;
    lines_done_d  = lines_done_q;
    spans_left_d  = spans_left_q;
    pixels_left_d = pixels_left_q;
    result_o.word_out   = word_i;
    result_o.was_pixel  = 1'b0;
    result_o.sprite_end = 1'b0;
    do_span = 1'b0;
    do_line = 1'b0;

    if (cfg_i.line_count == '0) begin
      phase_d       = PhSpans;
      lines_done_d  = '0;
      spans_left_d  = '0;
      pixels_left_d = '0;
      result_o.sprite_end = 1'b1;
    end else begin
      unique case (phase_q)
        PhSpans: begin
          if (word_i == '0) begin
            do_line = 1'b1;
          end else begin
            spans_left_d = word_i;
            phase_d      = PhSkip;
          end
        end
        PhSkip: begin
          phase_d = PhCount;
        end
        PhCount: begin
          if (word_i == '0) begin
            do_span = 1'b1;
          end else begin
            pixels_left_d = word_i;
            phase_d       = PhPixel;
          end
        end
        PhPixel: begin
          result_o.word_out  = sspfc_pkg::convert_pixel(word_i, cfg_i.to_555_mode);
          result_o.was_pixel = 1'b1;
          pixels_left_d      = pix_dec;
          do_span            = (pix_dec == '0);
        end
      endcase

      if (do_span) begin
        spans_left_d = span_dec;
        if (span_dec == '0) begin
          do_line = 1'b1;
        end else begin
          phase_d = PhSkip;
        end
      end

      if (do_line) begin
        phase_d       = PhSpans;
        spans_left_d  = '0;
        pixels_left_d = '0;
        if (line_last) begin
          lines_done_d        = '0;
          result_o.sprite_end = 1'b1;
        end else begin
          lines_done_d = lines_done_q + W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhSpans;
      lines_done_q  <= '0;
      spans_left_q  <= '0;
      pixels_left_q <= '0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      lines_done_q  <= lines_done_d;
      spans_left_q  <= spans_left_d;
      pixels_left_q <= pixels_left_d;
    end
  end

  // A pixel phase always has pixels still to come.
  a_pixels_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPixel |-> pixels_left_q != '0)
    else $error("pixel phase with no pixels left");

  // Inside a line the span counter is never zero.
  a_spans_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PhSpans |-> spans_left_q != '0)
    else $error("span phase with no spans left");

  // At a line boundary both span and pixel counters are cleared.
  a_line_start_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhSpans |-> (spans_left_q == '0) && (pixels_left_q == '0))
    else $error("line start with stale counters");

endmodule

>>> rtl/span_sprite_pixel_format_converter.sv
// Top level of the span sprite pixel format converter.
// Channel  | dir | payload                               | handshake
// in_i     | in  | word_in[15:0]                         | valid/ready
// out_o    | out | word_out[15:0], was_pixel, sprite_end | valid/ready
// cfg_i    | in  | index[7:0], data[15:0]                | valid/ready (always ready)
// One word per clock sustained while out_o is ready.
// The input register feeds the parser, whose result is captured in the output register.
// An output load moves both registers, so a stalled output holds the pipe without loss.
// Reset returns the parser to the span count of a new sprite, line count 0, 565-to-555 mode.
// Depends on sspfc_pkg, sspfc_if, sspfc_cfg_regs and sspfc_parser.
module span_sprite_pixel_format_converter (
  input  logic             clk_i,
  input  logic             rst_ni,
  sspfc_word_if.sink       in_i,
  sspfc_result_if.source   out_o,
  sspfc_cfg_if.sink        cfg_i
);

  localparam int unsigned W = sspfc_pkg::WordWidth;

  sspfc_pkg::cfg_t    cfg;
  sspfc_pkg::result_t parse_res;
  sspfc_pkg::result_t res_q;

  logic           in_valid_q;
  logic [W-1:0]   in_word_q;
  logic           out_valid_q;
  logic           load_out;
  logic           in_adv;

  assign cfg_i.ready = 1'b1;

  sspfc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  assign load_out   = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_adv     = !in_valid_q || load_out;
  assign in_i.ready = in_adv;

  sspfc_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (load_out),
    .word_i   (in_word_q),
    .cfg_i    (cfg),
    .result_o (parse_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid_q <= in_i.valid;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_i.valid) begin
      in_word_q <= in_i.word_in;
    end
    if (load_out) begin
      res_q <= parse_res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.word_out   = res_q.word_out;
  assign out_o.was_pixel  = res_q.was_pixel;
  assign out_o.sprite_end = res_q.sprite_end;

  // Input back-pressure only appears when both stages are full.
  a_full_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_valid_q && out_valid_q && !out_o.ready)
    else $error("input stalled with a free stage");

  // A beat in the input register is passed on the cycle after the output is taken.
  a_output_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_o.ready |=> out_valid_q)
    else $error("pending beat not moved to output");

endmodule
